FILE: sv/aldk_pkg.sv
// Package with shared types and fixed constants of the ladder keypad decoder.
package aldk_pkg;

	localparam int ADC_W       = 12;
	localparam int LEVEL_W     = 9;
	localparam int ADC_FULL_SH = 12;
	localparam int LEVEL_SCALE = 330;
	localparam int KEY_MAX     = 4;
	localparam int CFG_IDX_W   = 4;

	localparam logic [LEVEL_W-1:0] IDLE_LOW  = 9'd329;
	localparam logic [LEVEL_W-1:0] IDLE_HIGH = 9'd330;

	localparam int PRESS_W    = 8;
	localparam int RELEASE_W  = 9;
	localparam int HOLD_W     = 13;

	localparam logic [PRESS_W-1:0]   PRESS_MAX       = 8'd255;
	localparam logic [PRESS_W-1:0]   PRESS_THRESHOLD = 8'd3;
	localparam logic [RELEASE_W-1:0] CLEAR_TICKS     = 9'd500;
	localparam int BREATHE_START  = 6000;
	localparam int BREATHE_PERIOD = 1000;
	localparam int ARM_TICKS      = 8000;
	localparam int BREATHE_STEPS  = (ARM_TICKS - BREATHE_START) / BREATHE_PERIOD;

	typedef struct packed {
		logic [KEY_MAX-1:0] press;
		logic [KEY_MAX-1:0] in_win;
		logic [KEY_MAX-1:0] unlatch;
	} scan_res_t;

endpackage

FILE: sv/aldk_scan.sv
// Per-key window scan over the shared averaging buffer for one sample level.
module aldk_scan import aldk_pkg::*; #(
	parameter int KEY_COUNT     = 4,
	parameter int AVERAGE_DEPTH = 10,
	parameter int SLOT_W        = 4,
	parameter int SUM_W         = 12,
	parameter int LIM_W         = 13
) (
	input  logic [LEVEL_W-1:0] level,
	input  logic [SLOT_W-1:0]  slot,
	input  logic [SUM_W-1:0]   prefix,
	input  logic [KEY_MAX-1:0] latched,
	input  logic [LEVEL_W-1:0] win_lo [KEY_COUNT],
	input  logic [LEVEL_W-1:0] win_hi [KEY_COUNT],
	input  logic [LIM_W-1:0]   sum_lo [KEY_COUNT],
	input  logic [LIM_W-1:0]   sum_hi [KEY_COUNT],
	output logic [SLOT_W-1:0]  slot_next,
	output logic [SUM_W-1:0]   prefix_next,
	output scan_res_t          res
);

	always_comb begin
		logic [SLOT_W-1:0] s;
		logic [SUM_W-1:0]  p;
		logic [SUM_W-1:0]  total;
		logic              idle;
		s = slot;
		p = prefix;
		total = '0;
		res = '0;
		idle = (level >= IDLE_LOW) && (level <= IDLE_HIGH);
		for (int k = 0; k < KEY_COUNT; k++) begin
			if ((level >= win_lo[k]) && (level <= win_hi[k])) begin
				res.in_win[k] = 1'b1;
				if (s == SLOT_W'(AVERAGE_DEPTH - 1)) begin
					// The buffer holds the prefix plus this level once it fills.
					total = p + SUM_W'(level);
					s = '0;
					p = '0;
					if ((LIM_W'(total) >= sum_lo[k]) && (LIM_W'(total) < sum_hi[k])
							&& !latched[k]) begin
						res.press[k] = 1'b1;
					end
				end else begin
					s = SLOT_W'(s + 1'b1);
					p = p + SUM_W'(level);
				end
			end else if (idle) begin
				res.unlatch[k] = 1'b1;
			end
		end
		slot_next = s;
		prefix_next = p;
	end

endmodule

FILE: sv/adc_ladder_key_decoder.sv
// Top level of the resistor-ladder keypad decoder with press, breathe and reset logic.
//
// One ADC sample is accepted per clock while sample_stall is low; the input stage
// registers the scaled level, and the state stage then scans the key windows, updates
// the buffer and counters and loads the result register that drives the outputs.
// The sustained rate is one sample per cycle, limited only by result stalls. The
// configuration port is always ready; window registers must be written while no sample
// is in flight. The averaging buffer is kept as a running sum of the samples written
// since it last wrapped, so a full-buffer mean check is a compare of that sum against
// window bounds scaled by the buffer depth.
module adc_ladder_key_decoder import aldk_pkg::*; #(
	parameter int KEY_COUNT     = 4,
	parameter int AVERAGE_DEPTH = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  logic [ADC_W-1:0]     adc_code,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [KEY_MAX-1:0]   press_mask,
	output logic [KEY_MAX-1:0]   indicator_mask,
	output logic                 breathe_event,
	output logic                 breathe_on,
	output logic                 factory_reset,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data
);

	localparam int SLOT_W = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SUM_W  = $clog2(AVERAGE_DEPTH * 329 + 1);
	localparam int LIM_W  = $clog2(AVERAGE_DEPTH * 512 + 1);
	localparam int PROD_W = ADC_W + LEVEL_W;

	logic [LEVEL_W-1:0] win_lo_q [KEY_COUNT];
	logic [LEVEL_W-1:0] win_hi_q [KEY_COUNT];
	logic [LIM_W-1:0]   sum_lo_q [KEY_COUNT];
	logic [LIM_W-1:0]   sum_hi_q [KEY_COUNT];

	logic               valid_s1;
	logic [LEVEL_W-1:0] level_s1;
	logic [PROD_W-1:0]  scaled;
	logic               out_free;
	logic               adv;

	logic [SLOT_W-1:0]    slot_q;
	logic [SUM_W-1:0]     prefix_q;
	logic [KEY_MAX-1:0]   latched_q;
	logic [KEY_MAX-1:0]   indicator_q;
	logic [PRESS_W-1:0]   presses_q;
	logic [RELEASE_W-1:0] release_q;
	logic [HOLD_W-1:0]    hold_q;
	logic                 breathe_q;
	logic                 armed_q;

	logic                 result_valid_q;
	logic [KEY_MAX-1:0]   press_q;
	logic [KEY_MAX-1:0]   ind_out_q;
	logic                 bevent_q;
	logic                 bon_q;
	logic                 fire_q;

	logic [SLOT_W-1:0]    slot_n;
	logic [SUM_W-1:0]     prefix_n;
	scan_res_t            scan;

	logic [KEY_MAX-1:0]   latched_n;
	logic [KEY_MAX-1:0]   indicator_n;
	logic [PRESS_W-1:0]   presses_n;
	logic [RELEASE_W-1:0] release_n;
	logic [HOLD_W-1:0]    hold_n;
	logic                 breathe_n;
	logic                 armed_n;
	logic                 bevent_n;
	logic                 fire_n;
	logic                 held;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				win_lo_q[k] <= '0;
				win_hi_q[k] <= '0;
				sum_lo_q[k] <= '0;
				sum_hi_q[k] <= LIM_W'(AVERAGE_DEPTH);
			end
		end else if (cfg_valid && (cfg_index < CFG_IDX_W'(2 * KEY_COUNT))) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if (cfg_index[CFG_IDX_W-1:1] == (CFG_IDX_W-1)'(k)) begin
					if (cfg_index[0]) begin
						win_hi_q[k] <= cfg_data;
						sum_hi_q[k] <= LIM_W'((LIM_W'(cfg_data) + 1'b1) * LIM_W'(AVERAGE_DEPTH));
					end else begin
						win_lo_q[k] <= cfg_data;
						sum_lo_q[k] <= LIM_W'(LIM_W'(cfg_data) * LIM_W'(AVERAGE_DEPTH));
					end
				end
			end
		end
	end

	assign out_free     = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !out_free;
	assign adv          = valid_s1 && out_free;
	assign scaled       = PROD_W'(adc_code) * PROD_W'(LEVEL_SCALE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			level_s1 <= scaled[ADC_FULL_SH +: LEVEL_W];
		end
	end

	aldk_scan #(
		.KEY_COUNT     (KEY_COUNT),
		.AVERAGE_DEPTH (AVERAGE_DEPTH),
		.SLOT_W        (SLOT_W),
		.SUM_W         (SUM_W),
		.LIM_W         (LIM_W)
	) u_scan (
		.level       (level_s1),
		.slot        (slot_q),
		.prefix      (prefix_q),
		.latched     (latched_q),
		.win_lo      (win_lo_q),
		.win_hi      (win_hi_q),
		.sum_lo      (sum_lo_q),
		.sum_hi      (sum_hi_q),
		.slot_next   (slot_n),
		.prefix_next (prefix_n),
		.res         (scan)
	);

	always_comb begin
		logic [HOLD_W-1:0] h;
		h = hold_q;
		held = scan.in_win[0];
		latched_n = (latched_q & ~scan.unlatch) | scan.press;
		indicator_n = indicator_q ^ scan.press;
		presses_n = presses_q;
		release_n = release_q;
		hold_n = hold_q;
		breathe_n = breathe_q;
		armed_n = armed_q;
		bevent_n = 1'b0;
		if (scan.press[0]) begin
			if (presses_q != PRESS_MAX) begin
				presses_n = presses_q + 1'b1;
			end
			release_n = '0;
		end
		if (presses_n != '0) begin
			if ((presses_n >= PRESS_THRESHOLD) && held) begin
				h = hold_n + 1'b1;
				hold_n = h;
				for (int j = 0; j <= BREATHE_STEPS; j++) begin
					if (h == HOLD_W'(BREATHE_START + j * BREATHE_PERIOD)) begin
						bevent_n = 1'b1;
					end
				end
				if (bevent_n) begin
					breathe_n = !breathe_q;
				end
				if (h >= HOLD_W'(ARM_TICKS)) begin
					hold_n = '0;
					armed_n = 1'b1;
				end
			end
			if (!held) begin
				release_n = release_n + 1'b1;
				if (release_n >= CLEAR_TICKS) begin
					hold_n = '0;
					release_n = '0;
					presses_n = '0;
				end
			end
		end
		fire_n = armed_n && !held;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q      <= '0;
			prefix_q    <= '0;
			latched_q   <= '0;
			indicator_q <= '0;
			presses_q   <= '0;
			release_q   <= '0;
			hold_q      <= '0;
			breathe_q   <= 1'b0;
			armed_q     <= 1'b0;
		end else if (adv) begin
			if (fire_n) begin
				slot_q      <= '0;
				prefix_q    <= '0;
				latched_q   <= '0;
				indicator_q <= '0;
				presses_q   <= '0;
				release_q   <= '0;
				hold_q      <= '0;
				breathe_q   <= 1'b0;
				armed_q     <= 1'b0;
			end else begin
				slot_q      <= slot_n;
				prefix_q    <= prefix_n;
				latched_q   <= latched_n;
				indicator_q <= indicator_n;
				presses_q   <= presses_n;
				release_q   <= release_n;
				hold_q      <= hold_n;
				breathe_q   <= breathe_n;
				armed_q     <= armed_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			press_q   <= scan.press;
			ind_out_q <= indicator_n;
			bevent_q  <= bevent_n;
			bon_q     <= bevent_n && breathe_n;
			fire_q    <= fire_n;
		end
	end

	assign result_valid   = result_valid_q;
	assign press_mask     = press_q;
	assign indicator_mask = ind_out_q;
	assign breathe_event  = bevent_q;
	assign breathe_on     = bon_q;
	assign factory_reset  = fire_q;

endmodule

FILE: tb/ladder_key_check.sv
`timescale 1ns / 100ps
// Watches the keypad decoder's channels, predicts each tick's report and compares it.
module ladder_key_check import aldk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	input  logic                 sample_stall,
	input  logic [ADC_W-1:0]     adc_code,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [KEY_MAX-1:0]   press_mask,
	input  logic [KEY_MAX-1:0]   indicator_mask,
	input  logic                 breathe_event,
	input  logic                 breathe_on,
	input  logic                 factory_reset,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LEVEL_W-1:0]   cfg_data,
	output int                   mismatches,
	output int                   reports_due
);

	localparam int KEYS          = 4;
	localparam int AVG_DEPTH     = 10;
	localparam int REG_COUNT     = 8;
	localparam int VOLT_SCALE    = 330;
	localparam int IDLE_FLOOR    = 329;
	localparam int IDLE_CEIL     = 330;
	localparam int BREATHE_FIRST = 6000;
	localparam int BREATHE_GAP   = 1000;
	localparam int ARM_HOLD      = 8000;
	localparam int CLEAR_COUNT   = 500;
	localparam int PRESS_TRIGGER = 3;
	localparam int PRESS_CAP     = 255;

	typedef struct packed {
		logic [KEY_MAX-1:0] press;
		logic [KEY_MAX-1:0] lamps;
		logic               breathe_evt;
		logic               breathe_up;
		logic               fire;
	} key_report_t;

	logic [LEVEL_W-1:0] win_lo [KEYS];
	logic [LEVEL_W-1:0] win_hi [KEYS];
	logic [LEVEL_W-1:0] avg_buf [AVG_DEPTH];
	logic [3:0]         avg_slot;
	logic [KEYS-1:0]    latched;
	logic [KEYS-1:0]    lamps;
	logic [7:0]         key0_presses;
	logic [8:0]         release_cnt;
	logic [12:0]        hold_cnt;
	logic               breathe_lvl;
	logic               armed;

	key_report_t due_reports [$];
	key_report_t want_rep;
	key_report_t got_rep;

	function automatic logic in_win(input logic [LEVEL_W-1:0] v, input int k);
		return v >= win_lo[k] && v <= win_hi[k];
	endfunction

	task automatic clear_tracking();
		for (int i = 0; i < AVG_DEPTH; i++) avg_buf[i] = '0;
		avg_slot = '0;
		latched = '0;
		lamps = '0;
		key0_presses = '0;
		release_cnt = '0;
		hold_cnt = '0;
		breathe_lvl = 1'b0;
		armed = 1'b0;
	endtask

	task automatic decode_tick(input logic [ADC_W-1:0] code);
		logic [20:0]        scaled;
		logic [LEVEL_W-1:0] lvl;
		logic [LEVEL_W-1:0] mean;
		logic               held;
		int                 sum;
		key_report_t        rep;
		scaled = code * 21'(VOLT_SCALE);
		lvl = scaled[20:ADC_W];
		rep = '0;
		for (int k = 0; k < KEYS; k++) begin
			if (!in_win(lvl, k)) begin
				if (lvl >= IDLE_FLOOR && lvl <= IDLE_CEIL) latched[k] = 1'b0;
			end else begin
				avg_buf[avg_slot] = lvl;
				if (avg_slot != AVG_DEPTH - 1) begin
					avg_slot = avg_slot + 1'b1;
				end else begin
					avg_slot = '0;
					sum = 0;
					for (int i = 0; i < AVG_DEPTH; i++) sum += avg_buf[i];
					mean = LEVEL_W'(sum / AVG_DEPTH);
					if (in_win(mean, k) && !latched[k]) begin
						lamps[k] = ~lamps[k];
						rep.press[k] = 1'b1;
						latched[k] = 1'b1;
						if (k == 0) begin
							if (key0_presses != PRESS_CAP) key0_presses++;
							release_cnt = '0;
						end
					end
				end
			end
		end
		held = in_win(lvl, 0);
		if (key0_presses != 0) begin
			if (key0_presses >= PRESS_TRIGGER && held) begin
				hold_cnt++;
				if (hold_cnt >= BREATHE_FIRST && hold_cnt % BREATHE_GAP == 0) begin
					breathe_lvl = ~breathe_lvl;
					rep.breathe_evt = 1'b1;
					rep.breathe_up = breathe_lvl;
				end
				if (hold_cnt >= ARM_HOLD) begin
					hold_cnt = '0;
					armed = 1'b1;
				end
			end
			if (!held) begin
				release_cnt++;
				if (release_cnt >= CLEAR_COUNT) begin
					hold_cnt = '0;
					release_cnt = '0;
					key0_presses = '0;
				end
			end
		end
		rep.fire = armed && !held;
		rep.lamps = lamps;
		due_reports.push_back(rep);
		if (rep.fire) clear_tracking();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_tracking();
			for (int k = 0; k < KEYS; k++) begin
				win_lo[k] = '0;
				win_hi[k] = '0;
			end
			due_reports.delete();
			reports_due = 0;
			mismatches = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got_rep = {press_mask, indicator_mask, breathe_event, breathe_on, factory_reset};
				if (due_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Result with nothing expected: press %h lamps %h breathe %b/%b reset %b",
							got_rep.press, got_rep.lamps, got_rep.breathe_evt, got_rep.breathe_up,
							got_rep.fire);
				end else begin
					want_rep = due_reports.pop_front();
					if (got_rep !== want_rep) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"Mismatch: expected press %h lamps %h breathe %b/%b reset %b,",
								" got press %h lamps %h breathe %b/%b reset %b"},
								want_rep.press, want_rep.lamps, want_rep.breathe_evt,
								want_rep.breathe_up, want_rep.fire, got_rep.press, got_rep.lamps,
								got_rep.breathe_evt, got_rep.breathe_up, got_rep.fire);
					end
				end
			end
			if (cfg_valid && cfg_ready && cfg_index < REG_COUNT) begin
				if (cfg_index[0]) win_hi[cfg_index[2:1]] = cfg_data;
				else win_lo[cfg_index[2:1]] = cfg_data;
			end
			if (sample_valid && !sample_stall) decode_tick(adc_code);
			reports_due = due_reports.size();
		end
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the ladder keypad decoder: clock, reset, stimulus and verdict.
module tb_top;
	import aldk_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_KEY0_MIN = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY0_MAX = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1_MIN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY1_MAX = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2_MIN = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_KEY2_MAX = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3_MIN = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_KEY3_MAX = 4'd7;
	localparam int REG_COUNT     = 8;
	localparam int ADC_TOP       = (1 << ADC_W) - 1;
	localparam int IDLE_CODE_MIN = 4084;
	localparam int LEVEL_LIMIT   = 330;
	localparam int TOP_LEVEL     = 329;

	typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;
	typedef enum int {LAYOUT_LADDER, LAYOUT_OVERLAP, LAYOUT_EXTREME, LAYOUT_RANDOM} layout_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	logic [ADC_W-1:0]     adc_code = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	logic [KEY_MAX-1:0]   press_mask;
	logic [KEY_MAX-1:0]   indicator_mask;
	logic                 breathe_event;
	logic                 breathe_on;
	logic                 factory_reset;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [LEVEL_W-1:0]   cfg_data = '0;
	int                   mismatches;
	int                   reports_due;

	int          lo_of [4];
	int          hi_of [4];
	int          sent = 0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_left = 0;
	int          stall_phase = 0;

	logic [ADC_W-1:0] opening_codes [14] = '{12'd0, 12'd0, 12'd0, 12'd4095, 12'd12, 12'd13,
		12'd4084, 12'd4083, 12'd0, 12'd0, 12'd2048, 12'd4095, 12'd0, 12'd1365};

	adc_ladder_key_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .adc_code(adc_code),
		.result_valid(result_valid), .result_stall(result_stall),
		.press_mask(press_mask), .indicator_mask(indicator_mask),
		.breathe_event(breathe_event), .breathe_on(breathe_on), .factory_reset(factory_reset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	ladder_key_check keys_chk (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .adc_code(adc_code),
		.result_valid(result_valid), .result_stall(result_stall),
		.press_mask(press_mask), .indicator_mask(indicator_mask),
		.breathe_event(breathe_event), .breathe_on(breathe_on), .factory_reset(factory_reset),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .reports_due(reports_due)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 2));
			stall_left <= $urandom_range(50, 400);
		end else begin
			stall_left <= stall_left - 1;
		end
		stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
		case (stall_mode)
			STALL_NONE: result_stall <= 1'b0;
			STALL_RANDOM: result_stall <= ($urandom_range(0, 3) == 0);
			default: result_stall <= (stall_phase < 3);
		endcase
	end

	function automatic logic [ADC_W-1:0] code_in(input int lo, input int hi);
		int c_lo;
		int c_hi;
		if (lo > hi || lo > TOP_LEVEL) return ADC_W'($urandom_range(0, ADC_TOP));
		if (hi > TOP_LEVEL) hi = TOP_LEVEL;
		c_lo = (lo * 4096 + LEVEL_LIMIT - 1) / LEVEL_LIMIT;
		c_hi = ((hi + 1) * 4096 + LEVEL_LIMIT - 1) / LEVEL_LIMIT - 1;
		if (c_hi > ADC_TOP) c_hi = ADC_TOP;
		return ADC_W'($urandom_range(c_lo, c_hi));
	endfunction

	task automatic send_code(input logic [ADC_W-1:0] code);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_valid <= 1'b1;
		adc_code <= code;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do @(negedge clk); while (reports_due != 0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEVEL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic load_windows();
		write_reg(REG_KEY0_MIN, LEVEL_W'(lo_of[0]));
		write_reg(REG_KEY0_MAX, LEVEL_W'(hi_of[0]));
		write_reg(REG_KEY1_MIN, LEVEL_W'(lo_of[1]));
		write_reg(REG_KEY1_MAX, LEVEL_W'(hi_of[1]));
		write_reg(REG_KEY2_MIN, LEVEL_W'(lo_of[2]));
		write_reg(REG_KEY2_MAX, LEVEL_W'(hi_of[2]));
		write_reg(REG_KEY3_MIN, LEVEL_W'(lo_of[3]));
		write_reg(REG_KEY3_MAX, LEVEL_W'(hi_of[3]));
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)),
				LEVEL_W'($urandom_range(0, (1 << LEVEL_W) - 1)));
		cfg_valid <= 1'b0;
	endtask

	task automatic press_key0(input int count);
		repeat (count) begin
			repeat (10) send_code(code_in(lo_of[0], hi_of[0]));
			send_code(ADC_W'($urandom_range(IDLE_CODE_MIN, ADC_TOP)));
		end
	endtask

	initial begin
		int start;
		int pick;
		int key;
		int pos;
		int wait_cycles;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset windows are all 0..0, so level zero lands in every key at once.
		foreach (opening_codes[i]) send_code(opening_codes[i]);

		for (int p = 0; p < 8; p++) begin
			drain();
			case (layout_t'(p % 4))
				LAYOUT_LADDER: begin
					pos = $urandom_range(0, 20);
					for (int k = 0; k < 4; k++) begin
						lo_of[k] = pos;
						hi_of[k] = pos + $urandom_range(5, 50);
						pos = hi_of[k] + $urandom_range(1, 20);
					end
				end
				LAYOUT_OVERLAP: begin
					for (int k = 0; k < 4; k++) begin
						lo_of[k] = $urandom_range(0, 200);
						hi_of[k] = lo_of[k] + $urandom_range(20, 130);
					end
				end
				LAYOUT_EXTREME: begin
					if ($urandom_range(0, 1)) begin
						lo_of = '{0, 0, LEVEL_LIMIT, LEVEL_LIMIT};
						hi_of = '{LEVEL_LIMIT, 0, LEVEL_LIMIT, 0};
					end else begin
						lo_of = '{0, TOP_LEVEL, 0, 0};
						hi_of = '{LEVEL_LIMIT, LEVEL_LIMIT, LEVEL_LIMIT, LEVEL_LIMIT};
					end
				end
				default: begin
					for (int k = 0; k < 4; k++) begin
						lo_of[k] = $urandom_range(0, LEVEL_LIMIT);
						hi_of[k] = $urandom_range(0, LEVEL_LIMIT);
					end
				end
			endcase
			load_windows();
			start = sent;
			while (sent - start < 60) begin
				pick = $urandom_range(0, 11);
				if (pick < 6) begin
					key = $urandom_range(0, 3);
					repeat ($urandom_range(8, 13)) send_code(code_in(lo_of[key], hi_of[key]));
					if ($urandom_range(0, 1))
						send_code(ADC_W'($urandom_range(IDLE_CODE_MIN, ADC_TOP)));
				end else if (pick == 6) begin
					repeat ($urandom_range(1, 3))
						send_code(ADC_W'($urandom_range(IDLE_CODE_MIN, ADC_TOP)));
				end else if (pick == 7) begin
					repeat ($urandom_range(1, 4)) send_code(ADC_W'($urandom_range(0, ADC_TOP)));
				end else if (pick == 8) begin
					press_key0(3);
					repeat ($urandom_range(0, 30)) send_code(code_in(lo_of[0], hi_of[0]));
				end else if (pick == 9) begin
					case ($urandom_range(0, 3))
						0: send_code('0);
						1: send_code(ADC_W'(ADC_TOP));
						2: send_code(ADC_W'(IDLE_CODE_MIN - 1));
						default: send_code(ADC_W'(IDLE_CODE_MIN));
					endcase
				end else if (pick == 10) begin
					drain();
				end else begin
					send_code(ADC_W'($urandom_range(0, ADC_TOP)));
				end
			end
		end

		// Count three key 0 presses on a plain ladder, hold key 0 briefly, then release.
		drain();
		lo_of = '{20, 90, 160, 230};
		hi_of = '{60, 130, 200, 270};
		load_windows();
		press_key0(3);
		repeat (20) send_code(code_in(lo_of[0], hi_of[0]));
		repeat (3) send_code(ADC_W'($urandom_range(IDLE_CODE_MIN, ADC_TOP)));
		repeat (10) begin
			if ($urandom_range(0, 1)) send_code(ADC_W'($urandom_range(IDLE_CODE_MIN, ADC_TOP)));
			else send_code(code_in(lo_of[1], hi_of[1]));
		end
		press_key0(2);

		sample_valid <= 1'b0;
		for (wait_cycles = 0; wait_cycles < 10000 && reports_due != 0; wait_cycles++)
			@(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0 && reports_due == 0) begin
			$display("adc_ladder_key_decoder test passed");
		end else begin
			$display("adc_ladder_key_decoder test failed");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("adc_ladder_key_decoder test failed");
		$finish;
	end

endmodule
